FILE: hw/rtl/csmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants of the CSR sparse matrix-vector block.
// ----------------------------------------------------------------------------
package csmv_pkg;

  localparam int ADDR_W = 4;
  localparam int TW     = 97;  // row-end accumulator, holds alpha*sum + beta*y<<16

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic [1:0] REG_ALPHA     = 2'd0;
  localparam logic [1:0] REG_BETA      = 2'd1;
  localparam logic [1:0] REG_START_ROW = 2'd2;

  localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
  localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

  localparam logic [TW-1:0] ROUND_BIAS = TW'(1) << 31;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_X    = 3'd1,
    MUL_LO   = 3'd2,
    MUL_HI   = 3'd3,
    MUL_BY   = 3'd4
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_SUM   = 3'd1,
    ACC_INIT  = 3'd2,
    ACC_ADD32 = 3'd3,
    ACC_ADD16 = 3'd4
  } acc_sel_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul;
    acc_sel_t acc;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic closes;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] beta;
    logic [15:0] start_row;
    logic        row_load;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csmv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/csmv_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csmv_regs
// APB register file: alpha, beta, start_row.
// ----------------------------------------------------------------------------
module csmv_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [csmv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output csmv_pkg::cfg_t                   cfg
);
  import csmv_pkg::*;

  logic [31:0] alpha;
  logic [31:0] beta;
  logic [15:0] start_row;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      beta      <= BETA_RESET;
      start_row <= 16'd0;
    end else if (wr) begin
      case (idx)
        REG_ALPHA:     alpha     <= pwdata;
        REG_BETA:      beta      <= pwdata;
        REG_START_ROW: start_row <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA:     prdata = alpha;
      REG_BETA:      prdata = beta;
      REG_START_ROW: prdata = {16'd0, start_row};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.alpha     = alpha;
  assign cfg.beta      = beta;
  assign cfg.start_row = pwdata[15:0];
  assign cfg.row_load  = wr && (idx == REG_START_ROW);

endmodule
`default_nettype wire

FILE: hw/rtl/csmv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csmv_ctrl
// Sequencer: per-item multiply-accumulate and row-end scaling steps.
// ----------------------------------------------------------------------------
module csmv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       opcode,
  input  wire csmv_pkg::stat_t  stat,
  output logic                  in_stall,
  output csmv_pkg::cmd_t        cmd
);
  import csmv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MULX = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_LO   = 8'b0000_1000,
    S_HI   = 8'b0001_0000,
    S_BY   = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '{take: 1'b0, mul: MUL_NONE, acc: ACC_NONE, finish: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (opcode)
            OP_NZ:    state_next = S_MULX;
            OP_EMPTY: state_next = S_LO;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_MULX: begin
        cmd.mul    = MUL_X;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = ACC_SUM;
        state_next = stat.closes ? S_LO : S_IDLE;
      end
      S_LO: begin
        cmd.mul    = MUL_LO;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.mul    = MUL_HI;
        cmd.acc    = ACC_INIT;
        state_next = S_BY;
      end
      S_BY: begin
        cmd.mul    = MUL_BY;
        cmd.acc    = ACC_ADD32;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.acc    = ACC_ADD16;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/csmv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csmv_dp
// Datapath: x store, shared 33x33 multiplier, row sum, row-end accumulator,
// rounding, saturation and output register.
// ----------------------------------------------------------------------------
module csmv_dp #(
  parameter int VECTOR_LEN = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csmv_pkg::cmd_t     cmd,
  input  wire csmv_pkg::cfg_t     cfg,
  output csmv_pkg::stat_t         stat,
  input  wire logic [1:0]         opcode,
  input  wire logic [9:0]         column_index,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] previous_y,
  input  wire logic               closes_row,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             row_number,
  output logic signed [31:0]      result_value,
  output logic                    saturated
);
  import csmv_pkg::*;

  localparam int AW = $clog2(VECTOR_LEN);

  logic [16:0]        col_ext;
  logic [AW-1:0]      addr;
  logic               col_ok;
  logic               we;
  logic [31:0]        x_rd;

  logic signed [31:0] value_q;
  logic signed [31:0] prev_q;
  logic               closes_q;
  logic               ok_q;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  logic signed [63:0] prod;
  logic [TW-1:0]      prod_ext;

  logic [63:0]        row_sum;
  logic [TW-1:0]      t;
  logic [15:0]        row_counter;

  logic               fits;
  logic [31:0]        res;

  assign col_ext = {7'd0, column_index};
  assign addr    = col_ext[AW-1:0];
  assign col_ok  = (col_ext < 17'(VECTOR_LEN));
  assign we      = cmd.take && (opcode == OP_LOAD) && col_ok;

  csmv_ram #(
    .WIDTH (32),
    .DEPTH (VECTOR_LEN)
  ) u_xram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (element_value),
    .raddr (addr),
    .rdata (x_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_q  <= element_value;
      prev_q   <= previous_y;
      closes_q <= closes_row;
      ok_q     <= col_ok;
    end
  end

  always_comb begin
    case (cmd.mul)
      MUL_X: begin
        ma = {value_q[31], value_q};
        mb = ok_q ? {x_rd[31], x_rd} : 33'sd0;
      end
      MUL_LO: begin
        ma = {cfg.alpha[31], cfg.alpha};
        mb = {1'b0, row_sum[31:0]};
      end
      MUL_HI: begin
        ma = {cfg.alpha[31], cfg.alpha};
        mb = {row_sum[63], row_sum[63:32]};
      end
      MUL_BY: begin
        ma = {cfg.beta[31], cfg.beta};
        mb = {prev_q[31], prev_q};
      end
      default: begin
        ma = 33'sd0;
        mb = 33'sd0;
      end
    endcase
  end

  assign mp       = ma * mb;
  assign prod_ext = {{(TW-64){prod[63]}}, prod};

  always_ff @(posedge clk) begin
    prod <= mp[63:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.acc)
      ACC_INIT:  t <= prod_ext + ROUND_BIAS;
      ACC_ADD32: t <= t + (prod_ext << 32);
      ACC_ADD16: t <= t + (prod_ext << 16);
      default: ;
    endcase
  end

  // in range when bits 96..63 are all sign
  assign fits = (&t[TW-1:63]) || !(|t[TW-1:63]);
  assign res  = fits ? t[63:32] : (t[TW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum     <= 64'd0;
      row_counter <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.finish) begin
        row_sum <= 64'd0;
      end else if (cmd.acc == ACC_SUM) begin
        row_sum <= row_sum + prod;
      end
      if (cfg.row_load) begin
        row_counter <= cfg.start_row;
      end else if (cmd.finish) begin
        row_counter <= row_counter + 16'd1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      row_number   <= row_counter;
      result_value <= res;
      saturated    <= !fits;
    end
  end

  assign stat.closes   = closes_q;
  assign stat.out_busy = out_valid && out_stall;

endmodule
`default_nettype wire

FILE: hw/rtl/csr_sparse_matvec_axpby_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matvec_axpby_top
// y = alpha*A*x + beta*y over a CSR matrix stream, Q16.16, saturated output.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    opcode column_index element_value
//                                            previous_y closes_row
//   out      source     out_valid/out_stall  row_number result_value saturated
//   cfg      APB slave  psel/penable/pready  paddr pwdata prdata
//
// Load of x: written to the x store; input stays free. Nonzero: x read,
// multiply, accumulate. Row end runs through the one shared 33x33 multiplier
// (alpha*sum low, alpha*sum high, beta*y, final add, output), after a closing
// nonzero or directly for an empty row. Reset clears control state only; x is
// not cleared. The output step waits while an earlier result is still stalled.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_axpby_top #(
  parameter int VECTOR_LEN = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  opcode,
  input  wire logic [9:0]                  column_index,
  input  wire logic signed [31:0]          element_value,
  input  wire logic signed [31:0]          previous_y,
  input  wire logic                        closes_row,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [15:0]                      row_number,
  output logic signed [31:0]               result_value,
  output logic                             saturated,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [csmv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import csmv_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  cfg_t  cfg;

  csmv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  csmv_dp #(
    .VECTOR_LEN (VECTOR_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .stat          (stat),
    .opcode        (opcode),
    .column_index  (column_index),
    .element_value (element_value),
    .previous_y    (previous_y),
    .closes_row    (closes_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_number    (row_number),
    .result_value  (result_value),
    .saturated     (saturated)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result word overwritten while stalled");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished row not presented");

  a_nz_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == OP_NZ) |=> in_stall)
    else $error("nonzero accepted without busy period");

  a_take_match: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (in_valid && !in_stall))
    else $error("datapath latched a word that was not accepted");
`endif

endmodule
`default_nettype wire
